[rtl/core/trd_pkg.sv]
package trd_pkg;

    // Screen and vertex format
    localparam int SCREEN_W    = 1024;
    localparam int SCREEN_H    = 1024;
    localparam int SUB_BITS    = 4;
    localparam int STORE_DEPTH = SCREEN_W * SCREEN_H;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int DEPTH_W = 24;
    localparam int TEX_W   = 17;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;
    localparam logic [TEX_W-1:0]   TEX_MAX   = 17'd65536;

    // Shared arithmetic units
    localparam int MUL_W  = 25;
    localparam int DIV_NW = 60;
    localparam int DIV_DW = 50;
    localparam int RECIP_SHIFT  = 40;
    localparam int WEIGHT_SHIFT = 16;

    // Item codes
    localparam logic OP_VERTEX   = 1'b0;
    localparam logic OP_PIXEL    = 1'b1;
    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;
    localparam logic [1:0] SLOT_LAST = 2'd2;
    localparam logic [1:0] CORNER_LAST = 2'd2;

    // Cross product schedule
    localparam logic [2:0] CR_E0 = 3'd0;
    localparam logic [2:0] CR_E1 = 3'd1;
    localparam logic [2:0] CR_E2 = 3'd2;
    localparam logic [2:0] CR_S  = 3'd3;
    localparam logic [2:0] CR_N0 = 3'd4;
    localparam logic [2:0] CR_N1 = 3'd5;
    localparam logic [2:0] CR_N2 = 3'd6;
    localparam int NUM_CROSS = 7;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_VTX_BOX,
        ST_PIX_DIFF,
        ST_CR_A,
        ST_CR_B,
        ST_CR_C,
        ST_COVER,
        ST_W_DIV,
        ST_W_WAIT,
        ST_Q_DIV,
        ST_Q_WAIT,
        ST_T_MLO,
        ST_T_MHI,
        ST_T_ACC,
        ST_Z_DIV,
        ST_Z_WAIT,
        ST_B_MLO,
        ST_B_MHI,
        ST_B_ACC,
        ST_B_DIV,
        ST_B_WAIT,
        ST_RD,
        ST_TEST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

endpackage

[rtl/core/trd_ram.sv]
module trd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/trd_mul.sv]
module trd_mul (
    input  logic                             aclk,
    input  logic signed [trd_pkg::MUL_W-1:0]   a,
    input  logic signed [trd_pkg::MUL_W-1:0]   b,
    output logic signed [2*trd_pkg::MUL_W-1:0] p_reg
);

    // one registered product per cycle
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

endmodule

[rtl/core/trd_div.sv]
module trd_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  trd_pkg::div_req_t  req,
    output trd_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(trd_pkg::DIV_NW + 1);

    logic [trd_pkg::DIV_NW-1:0] work_reg;
    logic [trd_pkg::DIV_DW-1:0] rem_reg;
    logic [trd_pkg::DIV_DW-1:0] den_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [trd_pkg::DIV_DW:0]   trial;
    logic [trd_pkg::DIV_DW:0]   diff;
    logic                       fits;

    // restoring step: shift one dividend bit in, subtract when it fits
    always_comb begin
        trial = {rem_reg, work_reg[trd_pkg::DIV_NW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg && req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(trd_pkg::DIV_NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && req.start) begin
            work_reg <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? diff[trd_pkg::DIV_DW-1:0] : trial[trd_pkg::DIV_DW-1:0];
            work_reg <= {work_reg[trd_pkg::DIV_NW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = work_reg;

endmodule

[rtl/core/triangle_raster_depth_test.sv]
// Triangle rasterizer with a depth store, one triangle at a time.
// Input channel (s_valid/s_ready): a beat is either a vertex load
// (s_operation = 0, corner s_vertex_slot) or a pixel (s_operation = 1,
// s_pixel_x/s_pixel_y). Every input beat yields exactly one result beat on
// the m_ channel, in order. Loading corner 2 returns the bounding box.
// A pixel returns coverage at its centre, whether the depth store took the
// new depth, and the perspective-correct depth and texture coordinates.
// A covered pixel is dominated by nine divisions on the shared 60-step
// divider, with the 25x25 multiplier shared for cross products and partial
// products; a pixel that is not covered, or whose weights are void, skips them.
// One item is processed at a time; s_ready is high only in the idle state.
// Reset: the corners clear to zero and a clearing pass writes farthest depth
// into all 1,048,576 depth entries, one per cycle, before s_ready rises.
// Receiver stall: the result sits in the output register; the next input
// beat is still taken, and its result waits until the register frees up.
module triangle_raster_depth_test (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [1:0]  s_vertex_slot,
    input  logic [13:0] s_vertex_x,
    input  logic [13:0] s_vertex_y,
    input  logic [23:0] s_vertex_depth,
    input  logic [16:0] s_vertex_u,
    input  logic [16:0] s_vertex_v,
    input  logic [9:0]  s_pixel_x,
    input  logic [9:0]  s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [9:0]  m_box_min_x,
    output logic [9:0]  m_box_min_y,
    output logic [10:0] m_box_max_x,
    output logic [10:0] m_box_max_y,
    output logic        m_covered,
    output logic        m_written,
    output logic [23:0] m_frag_depth,
    output logic [16:0] m_frag_u,
    output logic [16:0] m_frag_v
);

    localparam int AW = trd_pkg::ADDR_W;
    localparam int MW = trd_pkg::MUL_W;
    localparam int NW = trd_pkg::DIV_NW;
    localparam int DW = trd_pkg::DIV_DW;

    trd_pkg::state_t state_reg, state_next;

    // corner store
    logic [13:0] cx_reg [3];
    logic [13:0] cy_reg [3];
    logic [23:0] cz_reg [3];
    logic [16:0] cu_reg [3];
    logic [16:0] cv_reg [3];

    // pixel working set
    logic [9:0]  pix_x_reg, pix_y_reg;
    logic [16:0] cdx_reg [3];
    logic [16:0] cdy_reg [3];
    logic [16:0] kx_reg [3];
    logic [16:0] ky_reg [3];
    logic [16:0] sax_reg, say_reg, sbx_reg, sby_reg;
    logic [34:0] cr_reg [trd_pkg::NUM_CROSS];
    logic [2:0]  k_reg;
    logic [1:0]  i_reg;
    logic        tex_sel_reg;
    logic signed [2*MW-1:0] p1_reg;
    logic [47:0] plo_reg;
    logic [DW-1:0] s_mag_reg;
    logic [34:0] n_mag_reg [3];
    logic [23:0] w_reg;
    logic [40:0] q_reg;
    logic [49:0] dsum_reg;
    logic [41:0] esum_reg;
    logic [39:0] e_reg [3];
    logic [58:0] acc_reg;

    // result being built
    logic        kind_reg;
    logic [9:0]  bminx_reg, bminy_reg;
    logic [10:0] bmaxx_reg, bmaxy_reg;
    logic        covered_reg, written_reg;
    logic [23:0] zf_reg;
    logic [16:0] fu_reg, fv_reg;

    logic [AW-1:0] clr_cnt_reg;
    logic          m_valid_reg;

    // shared units
    logic signed [MW-1:0]   mul_a, mul_b;
    logic signed [2*MW-1:0] mul_p;
    trd_pkg::div_req_t      div_req;
    trd_pkg::div_rsp_t      div_rsp;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [23:0]   ram_wdata;
    logic [AW-1:0] pix_addr;
    logic [23:0]   ram_rdata;

    // combinational helpers
    logic        accept;
    logic        can_load;
    logic [16:0] op_ax, op_ay, op_bx, op_by;
    logic [34:0] cr_val;
    logic [34:0] mag [trd_pkg::NUM_CROSS];
    logic        covers, degen, on_screen;
    logic [34:0] n_sel;
    logic [23:0] cz_sel;
    logic [39:0] e_sel;
    logic [16:0] t_sel;
    logic [63:0] wq_full;
    logic [47:0] term;
    logic [58:0] blend_add;
    logic [13:0] lx, ly, hx, hy;
    logic [31:0] bx_lo, by_lo, bx_hi, by_hi;
    logic [16:0] pcx, pcy, pcx0, pcy0;

    trd_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p_reg(mul_p)
    );

    trd_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    trd_ram #(
        .WIDTH(trd_pkg::DEPTH_W),
        .DEPTH(trd_pkg::STORE_DEPTH)
    ) u_depth (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(pix_addr),
        .rdata(ram_rdata)
    );

    assign accept   = s_valid && s_ready;
    assign can_load = !m_valid_reg || m_ready;
    assign pix_addr = AW'(32'(pix_y_reg) * trd_pkg::SCREEN_W + 32'(pix_x_reg));
    assign on_screen = (32'(pix_x_reg) < trd_pkg::SCREEN_W) &&
                       (32'(pix_y_reg) < trd_pkg::SCREEN_H);

    // pixel centre in half-subpixel units and pixel corner in subpixel units
    assign pcx  = 17'((32'(pix_x_reg) << (trd_pkg::SUB_BITS + 1)) +
                      (32'd1 << trd_pkg::SUB_BITS));
    assign pcy  = 17'((32'(pix_y_reg) << (trd_pkg::SUB_BITS + 1)) +
                      (32'd1 << trd_pkg::SUB_BITS));
    assign pcx0 = 17'(32'(pix_x_reg) << trd_pkg::SUB_BITS);
    assign pcy0 = 17'(32'(pix_y_reg) << trd_pkg::SUB_BITS);

    // cross product operands for the current schedule slot
    always_comb begin
        op_ax = '0;
        op_ay = '0;
        op_bx = '0;
        op_by = '0;
        case (k_reg)
            trd_pkg::CR_E0: begin
                op_ax = cdx_reg[0]; op_ay = cdy_reg[0];
                op_bx = cdx_reg[1]; op_by = cdy_reg[1];
            end
            trd_pkg::CR_E1: begin
                op_ax = cdx_reg[1]; op_ay = cdy_reg[1];
                op_bx = cdx_reg[2]; op_by = cdy_reg[2];
            end
            trd_pkg::CR_E2: begin
                op_ax = cdx_reg[2]; op_ay = cdy_reg[2];
                op_bx = cdx_reg[0]; op_by = cdy_reg[0];
            end
            trd_pkg::CR_S: begin
                op_ax = sax_reg; op_ay = say_reg;
                op_bx = sbx_reg; op_by = sby_reg;
            end
            trd_pkg::CR_N0: begin
                op_ax = kx_reg[1]; op_ay = ky_reg[1];
                op_bx = kx_reg[2]; op_by = ky_reg[2];
            end
            trd_pkg::CR_N1: begin
                op_ax = kx_reg[2]; op_ay = ky_reg[2];
                op_bx = kx_reg[0]; op_by = ky_reg[0];
            end
            trd_pkg::CR_N2: begin
                op_ax = kx_reg[0]; op_ay = ky_reg[0];
                op_bx = kx_reg[1]; op_by = ky_reg[1];
            end
            default: begin
                op_ax = '0;
            end
        endcase
    end

    // per-corner selection for the weight and blend loops
    always_comb begin
        case (i_reg)
            2'd0: begin
                n_sel = n_mag_reg[0]; cz_sel = cz_reg[0]; e_sel = e_reg[0];
                t_sel = tex_sel_reg ? cv_reg[0] : cu_reg[0];
            end
            2'd1: begin
                n_sel = n_mag_reg[1]; cz_sel = cz_reg[1]; e_sel = e_reg[1];
                t_sel = tex_sel_reg ? cv_reg[1] : cu_reg[1];
            end
            default: begin
                n_sel = n_mag_reg[2]; cz_sel = cz_reg[2]; e_sel = e_reg[2];
                t_sel = tex_sel_reg ? cv_reg[2] : cu_reg[2];
            end
        endcase
    end

    always_comb begin
        cr_val = p1_reg[34:0] - mul_p[34:0];
        for (int j = 0; j < trd_pkg::NUM_CROSS; j++) begin
            mag[j] = cr_reg[j][34] ? 35'(-cr_reg[j]) : cr_reg[j];
        end
        covers = (!cr_reg[trd_pkg::CR_E0][34] && !cr_reg[trd_pkg::CR_E1][34] &&
                  !cr_reg[trd_pkg::CR_E2][34]) ||
                 ((cr_reg[trd_pkg::CR_E0][34] || cr_reg[trd_pkg::CR_E0] == '0) &&
                  (cr_reg[trd_pkg::CR_E1][34] || cr_reg[trd_pkg::CR_E1] == '0) &&
                  (cr_reg[trd_pkg::CR_E2][34] || cr_reg[trd_pkg::CR_E2] == '0));
        degen  = (cr_reg[trd_pkg::CR_S]  == '0) || (cr_reg[trd_pkg::CR_N0] == '0) ||
                 (cr_reg[trd_pkg::CR_N1] == '0) || (cr_reg[trd_pkg::CR_N2] == '0);
        wq_full   = 64'(plo_reg) + (64'(mul_p[40:0]) << 24);
        term      = wq_full[63:16];
        blend_add = 59'(plo_reg) + (59'(mul_p[32:0]) << 24);
    end

    // bounding box over the three stored corners
    always_comb begin
        lx = cx_reg[0]; hx = cx_reg[0];
        ly = cy_reg[0]; hy = cy_reg[0];
        for (int j = 1; j < 3; j++) begin
            if (cx_reg[j] < lx) lx = cx_reg[j];
            if (cx_reg[j] > hx) hx = cx_reg[j];
            if (cy_reg[j] < ly) ly = cy_reg[j];
            if (cy_reg[j] > hy) hy = cy_reg[j];
        end
        bx_lo = 32'(lx) >> trd_pkg::SUB_BITS;
        by_lo = 32'(ly) >> trd_pkg::SUB_BITS;
        bx_hi = (32'(hx) + ((32'd1 << trd_pkg::SUB_BITS) - 32'd1)) >> trd_pkg::SUB_BITS;
        by_hi = (32'(hy) + ((32'd1 << trd_pkg::SUB_BITS) - 32'd1)) >> trd_pkg::SUB_BITS;
        if (bx_lo > 32'(trd_pkg::SCREEN_W - 1)) bx_lo = 32'(trd_pkg::SCREEN_W - 1);
        if (by_lo > 32'(trd_pkg::SCREEN_H - 1)) by_lo = 32'(trd_pkg::SCREEN_H - 1);
        if (bx_hi > 32'(trd_pkg::SCREEN_W)) bx_hi = 32'(trd_pkg::SCREEN_W);
        if (by_hi > 32'(trd_pkg::SCREEN_H)) by_hi = 32'(trd_pkg::SCREEN_H);
    end

    // sequencer: next state and unit controls
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_req    = '0;
        ram_we     = 1'b0;
        ram_waddr  = clr_cnt_reg;
        ram_wdata  = trd_pkg::DEPTH_MAX;
        case (state_reg)
            trd_pkg::ST_CLEAR: begin
                ram_we = 1'b1;
                if (clr_cnt_reg == AW'(trd_pkg::STORE_DEPTH - 1)) begin
                    state_next = trd_pkg::ST_IDLE;
                end
            end
            trd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == trd_pkg::OP_PIXEL) begin
                        state_next = trd_pkg::ST_PIX_DIFF;
                    end else if (s_vertex_slot == trd_pkg::SLOT_LAST) begin
                        state_next = trd_pkg::ST_VTX_BOX;
                    end else begin
                        state_next = trd_pkg::ST_DONE;
                    end
                end
            end
            trd_pkg::ST_VTX_BOX:  state_next = trd_pkg::ST_DONE;
            trd_pkg::ST_PIX_DIFF: state_next = trd_pkg::ST_CR_A;
            trd_pkg::ST_CR_A: begin
                mul_a = {{(MW-17){op_ax[16]}}, op_ax};
                mul_b = {{(MW-17){op_by[16]}}, op_by};
                state_next = trd_pkg::ST_CR_B;
            end
            trd_pkg::ST_CR_B: begin
                mul_a = {{(MW-17){op_ay[16]}}, op_ay};
                mul_b = {{(MW-17){op_bx[16]}}, op_bx};
                state_next = trd_pkg::ST_CR_C;
            end
            trd_pkg::ST_CR_C: begin
                state_next = (k_reg == trd_pkg::CR_N2) ? trd_pkg::ST_COVER
                                                       : trd_pkg::ST_CR_A;
            end
            trd_pkg::ST_COVER: begin
                if (!covers || degen) begin
                    state_next = trd_pkg::ST_DONE;
                end else begin
                    state_next = trd_pkg::ST_W_DIV;
                end
            end
            trd_pkg::ST_W_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = NW'(n_sel) << trd_pkg::WEIGHT_SHIFT;
                div_req.den   = s_mag_reg;
                state_next    = trd_pkg::ST_W_WAIT;
            end
            trd_pkg::ST_W_WAIT: begin
                if (div_rsp.done) state_next = trd_pkg::ST_Q_DIV;
            end
            trd_pkg::ST_Q_DIV: begin
                div_req.start = 1'b1;
                div_req.num   = NW'(1) << trd_pkg::RECIP_SHIFT;
                div_req.den   = (cz_sel == '0) ? DW'(1) : DW'(cz_sel);
                state_next    = trd_pkg::ST_Q_WAIT;
            end
            trd_pkg::ST_Q_WAIT: begin
                if (div_rsp.done) state_next = trd_pkg::ST_T_MLO;
            end
            trd_pkg::ST_T_MLO: begin
                mul_a = MW'(w_reg);
                mul_b = MW'(q_reg[23:0]);
                state_next = trd_pkg::ST_T_MHI;
            end
            trd_pkg::ST_T_MHI: begin
                mul_a = MW'(w_reg);
                mul_b = MW'(q_reg[40:24]);
                state_next = trd_pkg::ST_T_ACC;
            end
            trd_pkg::ST_T_ACC: begin
                state_next = (i_reg == trd_pkg::CORNER_LAST) ? trd_pkg::ST_Z_DIV
                                                             : trd_pkg::ST_W_DIV;
            end
            trd_pkg::ST_Z_DIV: begin
                if (dsum_reg == '0) begin
                    state_next = trd_pkg::ST_B_MLO;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'(1) << trd_pkg::RECIP_SHIFT;
                    div_req.den   = DW'(dsum_reg);
                    state_next    = trd_pkg::ST_Z_WAIT;
                end
            end
            trd_pkg::ST_Z_WAIT: begin
                if (div_rsp.done) state_next = trd_pkg::ST_B_MLO;
            end
            trd_pkg::ST_B_MLO: begin
                mul_a = MW'(e_sel[23:0]);
                mul_b = MW'(t_sel);
                state_next = trd_pkg::ST_B_MHI;
            end
            trd_pkg::ST_B_MHI: begin
                mul_a = MW'(e_sel[39:24]);
                mul_b = MW'(t_sel);
                state_next = trd_pkg::ST_B_ACC;
            end
            trd_pkg::ST_B_ACC: begin
                state_next = (i_reg == trd_pkg::CORNER_LAST) ? trd_pkg::ST_B_DIV
                                                             : trd_pkg::ST_B_MLO;
            end
            trd_pkg::ST_B_DIV: begin
                if (esum_reg == '0) begin
                    state_next = tex_sel_reg ? trd_pkg::ST_RD : trd_pkg::ST_B_MLO;
                end else begin
                    div_req.start = 1'b1;
                    div_req.num   = NW'(acc_reg);
                    div_req.den   = DW'(esum_reg);
                    state_next    = trd_pkg::ST_B_WAIT;
                end
            end
            trd_pkg::ST_B_WAIT: begin
                if (div_rsp.done) begin
                    state_next = tex_sel_reg ? trd_pkg::ST_RD : trd_pkg::ST_B_MLO;
                end
            end
            trd_pkg::ST_RD: begin
                state_next = on_screen ? trd_pkg::ST_TEST : trd_pkg::ST_DONE;
            end
            trd_pkg::ST_TEST: begin
                if (zf_reg <= ram_rdata) begin
                    ram_we    = 1'b1;
                    ram_waddr = pix_addr;
                    ram_wdata = zf_reg;
                end
                state_next = trd_pkg::ST_DONE;
            end
            trd_pkg::ST_DONE: begin
                if (can_load) state_next = trd_pkg::ST_IDLE;
            end
            default: state_next = trd_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= trd_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
            i_reg       <= '0;
            tex_sel_reg <= 1'b0;
            for (int j = 0; j < 3; j++) begin
                cx_reg[j] <= '0;
                cy_reg[j] <= '0;
                cz_reg[j] <= '0;
                cu_reg[j] <= '0;
                cv_reg[j] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == trd_pkg::ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            // output register: load on done, drop after the beat is taken
            if (state_reg == trd_pkg::ST_DONE && can_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && s_operation == trd_pkg::OP_VERTEX &&
                s_vertex_slot <= trd_pkg::SLOT_LAST) begin
                cx_reg[s_vertex_slot] <= s_vertex_x;
                cy_reg[s_vertex_slot] <= s_vertex_y;
                cz_reg[s_vertex_slot] <= s_vertex_depth;
                cu_reg[s_vertex_slot] <= s_vertex_u;
                cv_reg[s_vertex_slot] <= s_vertex_v;
            end
            case (state_reg)
                trd_pkg::ST_PIX_DIFF: k_reg <= '0;
                trd_pkg::ST_CR_C:     k_reg <= k_reg + 1'b1;
                trd_pkg::ST_COVER: begin
                    i_reg       <= '0;
                    tex_sel_reg <= 1'b0;
                end
                trd_pkg::ST_T_ACC, trd_pkg::ST_B_ACC: begin
                    i_reg <= (i_reg == trd_pkg::CORNER_LAST) ? 2'd0 : i_reg + 1'b1;
                end
                trd_pkg::ST_B_DIV: begin
                    if (esum_reg == '0) tex_sel_reg <= 1'b1;
                end
                trd_pkg::ST_B_WAIT: begin
                    if (div_rsp.done) tex_sel_reg <= 1'b1;
                end
                default: begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            trd_pkg::ST_IDLE: begin
                if (accept) begin
                    pix_x_reg   <= s_pixel_x;
                    pix_y_reg   <= s_pixel_y;
                    kind_reg    <= (s_operation == trd_pkg::OP_PIXEL) ? trd_pkg::KIND_PIXEL
                                                                      : trd_pkg::KIND_VERTEX;
                    bminx_reg   <= '0;
                    bminy_reg   <= '0;
                    bmaxx_reg   <= '0;
                    bmaxy_reg   <= '0;
                    covered_reg <= 1'b0;
                    written_reg <= 1'b0;
                    zf_reg      <= '0;
                    fu_reg      <= '0;
                    fv_reg      <= '0;
                end
            end
            trd_pkg::ST_VTX_BOX: begin
                bminx_reg <= 10'(bx_lo);
                bminy_reg <= 10'(by_lo);
                bmaxx_reg <= 11'(bx_hi);
                bmaxy_reg <= 11'(by_hi);
            end
            trd_pkg::ST_PIX_DIFF: begin
                for (int j = 0; j < 3; j++) begin
                    cdx_reg[j] <= 17'({cx_reg[j], 1'b0}) - pcx;
                    cdy_reg[j] <= 17'({cy_reg[j], 1'b0}) - pcy;
                    kx_reg[j]  <= 17'(cx_reg[j]) - pcx0;
                    ky_reg[j]  <= 17'(cy_reg[j]) - pcy0;
                end
                sax_reg <= 17'(cx_reg[1]) - 17'(cx_reg[0]);
                say_reg <= 17'(cy_reg[1]) - 17'(cy_reg[0]);
                sbx_reg <= 17'(cx_reg[2]) - 17'(cx_reg[0]);
                sby_reg <= 17'(cy_reg[2]) - 17'(cy_reg[0]);
            end
            trd_pkg::ST_CR_B: p1_reg <= mul_p;
            trd_pkg::ST_CR_C: cr_reg[k_reg] <= cr_val;
            trd_pkg::ST_COVER: begin
                covered_reg  <= covers;
                s_mag_reg    <= DW'(mag[trd_pkg::CR_S]);
                n_mag_reg[0] <= mag[trd_pkg::CR_N0];
                n_mag_reg[1] <= mag[trd_pkg::CR_N1];
                n_mag_reg[2] <= mag[trd_pkg::CR_N2];
                dsum_reg     <= '0;
                esum_reg     <= '0;
                acc_reg      <= '0;
            end
            trd_pkg::ST_W_WAIT: begin
                if (div_rsp.done) begin
                    w_reg <= (div_rsp.quo > NW'(trd_pkg::DEPTH_MAX)) ? trd_pkg::DEPTH_MAX
                                                                     : div_rsp.quo[23:0];
                end
            end
            trd_pkg::ST_Q_WAIT: begin
                if (div_rsp.done) q_reg <= div_rsp.quo[40:0];
            end
            trd_pkg::ST_T_MHI: plo_reg <= mul_p[47:0];
            trd_pkg::ST_T_ACC: begin
                dsum_reg     <= dsum_reg + 50'(term);
                esum_reg     <= esum_reg + 42'(term[47:8]);
                e_reg[i_reg] <= term[47:8];
            end
            trd_pkg::ST_Z_DIV: begin
                if (dsum_reg == '0) zf_reg <= trd_pkg::DEPTH_MAX;
            end
            trd_pkg::ST_Z_WAIT: begin
                if (div_rsp.done) begin
                    zf_reg <= (div_rsp.quo > NW'(trd_pkg::DEPTH_MAX)) ? trd_pkg::DEPTH_MAX
                                                                      : div_rsp.quo[23:0];
                end
            end
            trd_pkg::ST_B_MHI: plo_reg <= 48'(mul_p[40:0]);
            trd_pkg::ST_B_ACC: acc_reg <= acc_reg + blend_add;
            trd_pkg::ST_B_DIV: acc_reg <= '0;
            trd_pkg::ST_B_WAIT: begin
                if (div_rsp.done) begin
                    if (tex_sel_reg) begin
                        fv_reg <= (div_rsp.quo > NW'(trd_pkg::TEX_MAX)) ? trd_pkg::TEX_MAX
                                                                        : div_rsp.quo[16:0];
                    end else begin
                        fu_reg <= (div_rsp.quo > NW'(trd_pkg::TEX_MAX)) ? trd_pkg::TEX_MAX
                                                                        : div_rsp.quo[16:0];
                    end
                end
            end
            trd_pkg::ST_TEST: begin
                if (zf_reg <= ram_rdata) written_reg <= 1'b1;
            end
            default: begin
                kind_reg <= kind_reg;
            end
        endcase
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (state_reg == trd_pkg::ST_DONE && can_load) begin
            m_result_kind <= kind_reg;
            m_box_min_x   <= bminx_reg;
            m_box_min_y   <= bminy_reg;
            m_box_max_x   <= bmaxx_reg;
            m_box_max_y   <= bmaxy_reg;
            m_covered     <= covered_reg;
            m_written     <= written_reg;
            m_frag_depth  <= zf_reg;
            m_frag_u      <= fu_reg;
            m_frag_v      <= fv_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[rtl/core/trd_checker.sv]
module trd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_result_kind,
    input logic        m_covered,
    input logic        m_written,
    input logic [23:0] m_frag_depth,
    input logic [16:0] m_frag_u
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frag_depth) && $stable(m_covered))
        else $error("result beat changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channels active after reset");

    a_vertex_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == 1'b0 |-> !m_covered && !m_written)
        else $error("vertex answer carries pixel flags");

    a_write_needs_cover: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_written |-> m_covered)
        else $error("depth written for an uncovered pixel");

    a_uncovered_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_covered |-> m_frag_depth == '0 && m_frag_u == '0)
        else $error("uncovered pixel has fragment data");

endmodule

bind triangle_raster_depth_test trd_checker u_trd_checker (.*);
